// ===== hw/rtl/cts_pkg.sv =====
// Package for the cooperative task scheduler: command, kind and status codes,
// field widths and the structs shared by the front, back and top level.
// Depends on nothing.
package cts_pkg;

   localparam int DEFAULT_NUM_SLOTS = 8;
   localparam int QUEUE_DEPTH       = 2;

   localparam int CMD_W    = 2;
   localparam int TAG_W    = 16;
   localparam int TIME_W   = 31;
   localparam int DELAY_W  = 33;
   localparam int SLOT_W   = 3;
   localparam int ELAPSE_W = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [TAG_W-1:0]    task_tag;
      logic [TIME_W-1:0]   first_delay;
      logic [TIME_W-1:0]   repeat_period;
      logic [SLOT_W-1:0]   slot;
      logic [ELAPSE_W-1:0] elapsed;
   } cts_cmd_type;

   typedef struct packed {
      logic [TAG_W-1:0]          tag;
      logic signed [DELAY_W-1:0] delay;
      logic [TIME_W-1:0]         period;
   } cts_slot_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SLOT_W-1:0]   slot_out;
      logic [TAG_W-1:0]    tag_out;
      logic [STATUS_W-1:0] status;
      logic                last;
   } cts_rsp_type;

endpackage

// ===== hw/rtl/cts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cts_front.sv =====
// Front part of the scheduler: accepts request beats, drops undefined commands
// and queues the rest for the back part. Depends on cts_pkg.
module cts_front
   import cts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [TAG_W-1:0]    req_task_tag,
   input  logic [TIME_W-1:0]   req_first_delay,
   input  logic [TIME_W-1:0]   req_repeat_period,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [ELAPSE_W-1:0] req_elapsed,
   output logic                q_valid,
   output cts_cmd_type         q_entry,
   input  logic                q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cts_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;
   logic             known_cmd;

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign known_cmd = (req_cmd == CMD_ADD) || (req_cmd == CMD_DELETE) || (req_cmd == CMD_TICK);
   assign push      = req_valid && !req_stall && known_cmd;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{cmd:           req_cmd,
                                  task_tag:      req_task_tag,
                                  first_delay:   req_first_delay,
                                  repeat_period: req_repeat_period,
                                  slot:          req_slot,
                                  elapsed:       req_elapsed};
      end
   end

endmodule

// ===== hw/rtl/cts_back.sv =====
// Back part of the scheduler: slot valid bits, slot RAM and the sequencer
// that carries out add, delete and tick. Depends on cts_pkg and cts_ram.
module cts_back
   import cts_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cts_cmd_type q_entry,
   output logic        q_pop,
   output cts_rsp_type rsp,
   output logic        rsp_valid,
   input  logic        rsp_stall
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_DEL,
      ST_TICK,
      ST_END
   } state_type;

   state_type            state_ff, state_in;
   cts_cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [TAG_W-1:0]     pend_tag_ff, pend_tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cts_rsp_type          rsp_ff, rsp_in;

   logic                      out_free;
   logic [IDX_W-1:0]          cnt_idx;
   logic [CNT_W+SLOT_W-1:0]   cnt_ext;
   logic [SLOT_W-1:0]         cnt_slot;
   logic [IDX_W+SLOT_W-1:0]   sel_ext;
   logic [IDX_W-1:0]          sel_idx;
   logic                      sel_bad;
   logic                      ram_wr_en;
   logic [IDX_W-1:0]          ram_wr_addr;
   cts_slot_type              ram_wr_data;
   logic                      ram_rd_en;
   logic [IDX_W-1:0]          ram_rd_addr;
   cts_slot_type              ram_rd_data;
   logic signed [DELAY_W-1:0] delay_dec;
   logic signed [DELAY_W-1:0] delay_reload;
   logic                      tick_go;

   cts_ram #(
      .WIDTH($bits(cts_slot_type)),
      .DEPTH(NUM_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_idx   = cnt_ff[IDX_W-1:0];
   assign cnt_ext   = {{SLOT_W{1'b0}}, cnt_ff};
   assign cnt_slot  = cnt_ext[SLOT_W-1:0];
   assign sel_ext   = {{IDX_W{1'b0}}, cmd_ff.slot};
   assign sel_idx   = sel_ext[IDX_W-1:0];
   assign sel_bad   = (32'(cmd_ff.slot) >= 32'(NUM_SLOTS));
   assign delay_dec    = ram_rd_data.delay - {{(DELAY_W-ELAPSE_W){1'b0}}, cmd_ff.elapsed};
   assign delay_reload = {{(DELAY_W-TIME_W){1'b0}}, ram_rd_data.period}
                         - {{(DELAY_W-ELAPSE_W){1'b0}}, cmd_ff.elapsed};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cnt_idx;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      tick_go       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_entry;
               cnt_in = '0;
               case (q_entry.cmd)
                  CMD_ADD:    state_in = ST_ADD;
                  CMD_DELETE: state_in = ST_DEL;
                  CMD_TICK: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_TICK;
                  end
                  default:    state_in = ST_IDLE;
               endcase
            end
         end

         ST_ADD: begin
            if (cnt_ff == CNT_W'(NUM_SLOTS)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{KIND_ADD, '0, '0, STATUS_FULL, 1'b1};
                  state_in     = ST_IDLE;
               end
            end else if (valid_ff[cnt_idx]) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (out_free) begin
               ram_wr_en         = 1'b1;
               ram_wr_data.tag   = cmd_ff.task_tag;
               ram_wr_data.delay = {{(DELAY_W-TIME_W){1'b0}}, cmd_ff.first_delay};
               ram_wr_data.period = cmd_ff.repeat_period;
               valid_in[cnt_idx] = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_in            = '{KIND_ADD, cnt_slot, '0, STATUS_OK, 1'b1};
               state_in          = ST_IDLE;
            end
         end

         ST_DEL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (sel_bad) begin
                  rsp_in = '{KIND_DELETE, cmd_ff.slot, '0, STATUS_BAD_IDX, 1'b1};
               end else begin
                  valid_in[sel_idx] = 1'b0;
                  rsp_in = '{KIND_DELETE, cmd_ff.slot, '0, STATUS_OK, 1'b1};
               end
            end
         end

         ST_TICK: begin
            if (!valid_ff[cnt_idx]) begin
               tick_go = 1'b1;
            end else if (!ram_rd_data.delay[DELAY_W-1]) begin
               tick_go           = 1'b1;
               ram_wr_en         = 1'b1;
               ram_wr_data.delay = delay_dec;
            end else if (!pend_valid_ff || out_free) begin
               tick_go = 1'b1;
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{KIND_FIRED, pend_slot_ff, pend_tag_ff, STATUS_OK, 1'b0};
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = cnt_slot;
               pend_tag_in   = ram_rd_data.tag;
               if (ram_rd_data.period != '0) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_data.delay = delay_reload;
               end else begin
                  valid_in[cnt_idx] = 1'b0;
               end
            end
            if (tick_go) begin
               if (cnt_ff == CNT_W'(NUM_SLOTS - 1)) begin
                  state_in = ST_END;
               end else begin
                  cnt_in      = cnt_ff + CNT_W'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = cnt_in[IDX_W-1:0];
               end
            end
         end

         ST_END: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
               if (pend_valid_ff) begin
                  rsp_in = '{KIND_FIRED, pend_slot_ff, pend_tag_ff, STATUS_OK, 1'b1};
               end else begin
                  rsp_in = '{KIND_IDLE, '0, '0, STATUS_OK, 1'b1};
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/cooperative_task_scheduler_unit.sv =====
// Cooperative task scheduler. Items are carried out one at a time: the back part
// does not take a new request until it has issued the last response beat of the
// current one. A tick visits one slot per cycle through the read port of the slot
// RAM, unless a fired beat is held up by a response stall.
// Synchronous reset empties the two-beat queue and frees every slot.
module cooperative_task_scheduler_unit
   import cts_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [TAG_W-1:0]    req_task_tag,
   input  logic [TIME_W-1:0]   req_first_delay,
   input  logic [TIME_W-1:0]   req_repeat_period,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [ELAPSE_W-1:0] req_elapsed,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [SLOT_W-1:0]   rsp_slot_out,
   output logic [TAG_W-1:0]    rsp_tag_out,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   logic        q_valid;
   logic        q_pop;
   cts_cmd_type q_entry;
   cts_rsp_type rsp;

   cts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_task_tag     (req_task_tag),
      .req_first_delay  (req_first_delay),
      .req_repeat_period(req_repeat_period),
      .req_slot         (req_slot),
      .req_elapsed      (req_elapsed),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop)
   );

   cts_back #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .rsp      (rsp),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall)
   );

   assign rsp_kind     = rsp.kind;
   assign rsp_slot_out = rsp.slot_out;
   assign rsp_tag_out  = rsp.tag_out;
   assign rsp_status   = rsp.status;
   assign rsp_last     = rsp.last;

endmodule

// ===== tb/sv/cts_schedule_checker.sv =====
// Checker for the cooperative task scheduler: watches the request and response
// channels, keeps its own copy of the slot table and compares every response beat.
// Depends on cts_pkg.
module cts_schedule_checker
   import cts_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [TAG_W-1:0]    req_task_tag,
   input  logic [TIME_W-1:0]   req_first_delay,
   input  logic [TIME_W-1:0]   req_repeat_period,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [ELAPSE_W-1:0] req_elapsed,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [KIND_W-1:0]   rsp_kind,
   input  logic [SLOT_W-1:0]   rsp_slot_out,
   input  logic [TAG_W-1:0]    rsp_tag_out,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  outstanding
);

   logic                      live [NUM_SLOTS];
   logic [TAG_W-1:0]          tag_of [NUM_SLOTS];
   logic signed [DELAY_W-1:0] delay_left [NUM_SLOTS];
   logic [TIME_W-1:0]         period_of [NUM_SLOTS];
   cts_rsp_type               awaited_rsp [$];

   function automatic cts_rsp_type make_rsp(input logic [KIND_W-1:0] kind,
                                            input int slot,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [STATUS_W-1:0] status,
                                            input logic last);
      cts_rsp_type r;
      r.kind = kind;
      r.slot_out = SLOT_W'(slot);
      r.tag_out = tag;
      r.status = status;
      r.last = last;
      return r;
   endfunction

   task automatic free_slot(input int i);
      live[i] = 1'b0;
      tag_of[i] = '0;
      delay_left[i] = '0;
      period_of[i] = '0;
   endtask

   task automatic apply_command(input cts_cmd_type c);
      int free_at;
      int fired;
      cts_rsp_type held;
      free_at = -1;
      fired = 0;
      case (c.cmd)
         CMD_ADD: begin
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
               if (!live[i]) free_at = i;
            end
            if (free_at < 0) begin
               awaited_rsp.push_back(make_rsp(KIND_ADD, 0, '0, STATUS_FULL, 1'b1));
            end else begin
               live[free_at] = 1'b1;
               tag_of[free_at] = c.task_tag;
               delay_left[free_at] = $signed({2'b00, c.first_delay});
               period_of[free_at] = c.repeat_period;
               awaited_rsp.push_back(make_rsp(KIND_ADD, free_at, '0, STATUS_OK, 1'b1));
            end
         end
         CMD_DELETE: begin
            if (int'(c.slot) >= NUM_SLOTS) begin
               awaited_rsp.push_back(make_rsp(KIND_DELETE, int'(c.slot), '0,
                                              STATUS_BAD_IDX, 1'b1));
            end else begin
               free_slot(int'(c.slot));
               awaited_rsp.push_back(make_rsp(KIND_DELETE, int'(c.slot), '0,
                                              STATUS_OK, 1'b1));
            end
         end
         CMD_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (live[i]) begin
                  if (delay_left[i] < 0) begin
                     if (fired > 0) awaited_rsp.push_back(held);
                     held = make_rsp(KIND_FIRED, i, tag_of[i], STATUS_OK, 1'b0);
                     fired++;
                     if (period_of[i] != '0) begin
                        delay_left[i] = $signed({2'b00, period_of[i]})
                                        - $signed({17'b0, c.elapsed});
                     end else begin
                        free_slot(i);
                     end
                  end else begin
                     delay_left[i] = delay_left[i] - $signed({17'b0, c.elapsed});
                  end
               end
            end
            if (fired == 0) begin
               awaited_rsp.push_back(make_rsp(KIND_IDLE, 0, '0, STATUS_OK, 1'b1));
            end else begin
               held.last = 1'b1;
               awaited_rsp.push_back(held);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cts_rsp_type want;
      cts_cmd_type c;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) free_slot(i);
         awaited_rsp.delete();
         outstanding = 0;
      end else begin
         // A response beat can never belong to the request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               report("beat with nothing expected, kind", 32'(rsp_kind), '0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_kind !== want.kind) begin
                  report("kind", 32'(rsp_kind), 32'(want.kind));
               end
               if (rsp_slot_out !== want.slot_out) begin
                  report("slot_out", 32'(rsp_slot_out), 32'(want.slot_out));
               end
               if (rsp_tag_out !== want.tag_out) begin
                  report("tag_out", 32'(rsp_tag_out), 32'(want.tag_out));
               end
               if (rsp_status !== want.status) begin
                  report("status", 32'(rsp_status), 32'(want.status));
               end
               if (rsp_last !== want.last) begin
                  report("last", 32'(rsp_last), 32'(want.last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            c.cmd = req_cmd;
            c.task_tag = req_task_tag;
            c.first_delay = req_first_delay;
            c.repeat_period = req_repeat_period;
            c.slot = req_slot;
            c.elapsed = req_elapsed;
            apply_command(c);
         end
         outstanding = awaited_rsp.size();
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the cooperative task scheduler: clock, reset, request
// stimulus, response stalls, watchdog and verdict.
// Depends on cts_pkg, cts_schedule_checker and cooperative_task_scheduler_unit.
module tb
   import cts_pkg::*;
();

   localparam int NUM_SLOTS = DEFAULT_NUM_SLOTS;
   localparam int RANDOM_ITEMS = 260;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [TAG_W-1:0]    req_task_tag = '0;
   logic [TIME_W-1:0]   req_first_delay = '0;
   logic [TIME_W-1:0]   req_repeat_period = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [ELAPSE_W-1:0] req_elapsed = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   int fail_count;
   int outstanding;
   int burst_left = 0;
   int stall_left = 0;
   int steady_left = 0;
   int quiet_cycles = 0;

   cooperative_task_scheduler_unit #(.NUM_SLOTS(NUM_SLOTS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_task_tag(req_task_tag),
      .req_first_delay(req_first_delay),
      .req_repeat_period(req_repeat_period),
      .req_slot(req_slot),
      .req_elapsed(req_elapsed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_slot_out(rsp_slot_out),
      .rsp_tag_out(rsp_tag_out),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   cts_schedule_checker #(.NUM_SLOTS(NUM_SLOTS)) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_task_tag(req_task_tag),
      .req_first_delay(req_first_delay),
      .req_repeat_period(req_repeat_period),
      .req_slot(req_slot),
      .req_elapsed(req_elapsed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_slot_out(rsp_slot_out),
      .rsp_tag_out(rsp_tag_out),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (steady_left > 0) begin
         steady_left <= steady_left - 1;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 99) < 3) steady_left <= $urandom_range(20, 80);
         else stall_left <= idle_span();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic cts_cmd_type make_cmd(input logic [CMD_W-1:0] cmd,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [TIME_W-1:0] first_delay,
                                            input logic [TIME_W-1:0] period,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [ELAPSE_W-1:0] elapsed);
      cts_cmd_type c;
      c.cmd = cmd;
      c.task_tag = tag;
      c.first_delay = first_delay;
      c.repeat_period = period;
      c.slot = slot;
      c.elapsed = elapsed;
      return c;
   endfunction

   function automatic cts_cmd_type random_cmd();
      cts_cmd_type c;
      int r;
      r = $urandom_range(0, 99);
      if (r < 34) c.cmd = CMD_ADD;
      else if (r < 52) c.cmd = CMD_DELETE;
      else if (r < 97) c.cmd = CMD_TICK;
      else c.cmd = CMD_UNDEFINED;
      c.task_tag = TAG_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) < 8) c.first_delay = TIME_W'($urandom_range(0, 300));
      else c.first_delay = TIME_W'($urandom());
      r = $urandom_range(0, 99);
      if (r < 40) c.repeat_period = '0;
      else if (r < 85) c.repeat_period = TIME_W'($urandom_range(1, 300));
      else c.repeat_period = TIME_W'($urandom());
      c.slot = SLOT_W'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 80) c.elapsed = ELAPSE_W'($urandom_range(0, 100));
      else if (r < 95) c.elapsed = ELAPSE_W'($urandom_range(0, 65535));
      else c.elapsed = '1;
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send(input cts_cmd_type item);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 99) < 4) begin
         burst_left = $urandom_range(15, 40);
         gap = 0;
      end else begin
         gap = idle_span();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= item.cmd;
      req_task_tag <= item.task_tag;
      req_first_delay <= item.first_delay;
      req_repeat_period <= item.repeat_period;
      req_slot <= item.slot;
      req_elapsed <= item.elapsed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   initial begin
      cts_cmd_type item;
      int counted;
      counted = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(make_cmd(CMD_TICK, '0, '0, '0, '0, '0));
      send(make_cmd(CMD_ADD, '0, '0, '0, '0, '0));
      send(make_cmd(CMD_ADD, '1, '1, '1, '1, '1));
      send(make_cmd(CMD_TICK, '0, '0, '0, '0, 16'd1));
      send(make_cmd(CMD_TICK, '0, '0, '0, '0, '1));
      for (int t = 1; t <= 7; t++) begin
         send(make_cmd(CMD_ADD, TAG_W'(t), '0, (t == 1) ? '0 : TIME_W'(3 * t), '0, '0));
      end
      send(make_cmd(CMD_ADD, 16'hBEEF, 31'd5, 31'd5, '0, '0));
      send(make_cmd(CMD_DELETE, '0, '0, '0, 3'd7, '0));
      send(make_cmd(CMD_DELETE, '0, '0, '0, 3'd7, '0));
      send(make_cmd(CMD_DELETE, '0, '0, '0, 3'd0, '0));
      send(make_cmd(CMD_TICK, '0, '0, '0, '0, '0));
      send(make_cmd(CMD_TICK, '0, '0, '0, '0, 16'd2));
      send(make_cmd(CMD_TICK, '0, '0, '0, '0, 16'd5));
      send(make_cmd(CMD_UNDEFINED, '1, '1, '1, '1, '1));
      send(make_cmd(CMD_TICK, '0, '0, '0, '0, '1));
      send(make_cmd(CMD_TICK, '0, '0, '0, '0, '1));
      wait_drained();

      while (counted < RANDOM_ITEMS) begin
         item = random_cmd();
         send(item);
         if (item.cmd != CMD_UNDEFINED) counted++;
         if ($urandom_range(0, 59) == 0) wait_drained();
      end

      wait_drained();
      repeat (2 * NUM_SLOTS + 8) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
